@@ rtl/ensc_pkg.sv @@
package ensc_pkg;

   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 48;

   // register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAL_TEMP    = 3'd0,
      CSR_CAL_PRESS_A = 3'd1,
      CSR_CAL_PRESS_B = 3'd2,
      CSR_CAL_PRESS_C = 3'd3,
      CSR_CAL_HUM_A   = 3'd4,
      CSR_CAL_HUM_B   = 3'd5
   } csr_reg_type;

   // pipeline depths, counted in register stages from the accepted request
   localparam int unsigned FINE_LAT = 4;
   localparam int unsigned TEMP_LAT = 5;
   localparam int unsigned HUM_LAT = 12;
   localparam int unsigned DIV_STAGES = 32;
   localparam int unsigned PIPE_LAT = FINE_LAT + 6 + DIV_STAGES + 3;

   localparam logic [31:0] HUM_MAX = 32'd419430400;

   // calibration words, already extended to 32 bits
   typedef struct packed {
      logic [31:0] t1;
      logic [31:0] t2;
      logic [31:0] t3;
      logic [31:0] p1;
      logic [31:0] p2;
      logic [31:0] p3;
      logic [31:0] p4;
      logic [31:0] p5;
      logic [31:0] p6;
      logic [31:0] p7;
      logic [31:0] p8;
      logic [31:0] p9;
      logic [31:0] h1;
      logic [31:0] h2;
      logic [31:0] h3;
      logic [31:0] h4;
      logic [31:0] h5;
      logic [31:0] h6;
   } cal_type;

   typedef struct packed {
      logic dbl;
      logic zero;
   } div_tag_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] dvd;
      logic [31:0] quo;
      logic [31:0] dsr;
      div_tag_type tag;
   } div_stage_type;

   function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
      return 32'($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] sx8(input logic [7:0] v);
      return {{24{v[7]}}, v};
   endfunction

endpackage

@@ rtl/ensc_temp.sv @@
module ensc_temp (
   input  logic              clock,
   input  logic              adv,
   input  logic [19:0]       adc_temp,
   input  ensc_pkg::cal_type cal,
   output logic [31:0]       fine,
   output logic [31:0]       temp
);
   import ensc_pkg::*;

   logic [31:0] a_ff, d_ff, m1_ff, dd_ff, v1_ff, m2_ff, fine_ff, temp_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff    <= 32'(adc_temp >> 3) - (cal.t1 << 1);
         d_ff    <= 32'(adc_temp >> 4) - cal.t1;
         m1_ff   <= a_ff * cal.t2;
         dd_ff   <= d_ff * d_ff;
         v1_ff   <= asr(m1_ff, 11);
         m2_ff   <= asr(dd_ff, 12) * cal.t3;
         fine_ff <= v1_ff + asr(m2_ff, 14);
         // fine * 5 as shift and add
         temp_ff <= asr((fine_ff << 2) + fine_ff + 32'd128, 8);
      end
   end

   assign fine = fine_ff;
   assign temp = temp_ff;

endmodule

@@ rtl/ensc_div.sv @@
module ensc_div (
   input  logic                  clock,
   input  logic                  adv,
   input  logic [31:0]           dividend,
   input  logic [31:0]           divisor,
   input  ensc_pkg::div_tag_type tag_in,
   output logic [31:0]           quotient,
   output ensc_pkg::div_tag_type tag_out
);
   import ensc_pkg::*;

   div_stage_type src [DIV_STAGES];
   div_stage_type stage_in [DIV_STAGES];
   div_stage_type stage_ff [DIV_STAGES];

   assign src[0] = '{rem: '0, dvd: dividend, quo: '0, dsr: divisor, tag: tag_in};

   genvar k;
   generate
      for (k = 0; k < DIV_STAGES; k++) begin : g_stage
         logic [32:0] trial;
         logic        ge;

         if (k > 0) begin : g_link
            assign src[k] = stage_ff[k-1];
         end

         // one quotient bit per stage, restoring
         always_comb begin
            trial = {src[k].rem, src[k].dvd[31]};
            ge = trial >= {1'b0, src[k].dsr};
            stage_in[k] = src[k];
            stage_in[k].rem = ge ? 32'(trial - {1'b0, src[k].dsr}) : trial[31:0];
            stage_in[k].dvd = src[k].dvd << 1;
            stage_in[k].quo = {src[k].quo[30:0], ge};
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               stage_ff[k] <= stage_in[k];
            end
         end
      end
   endgenerate

   assign quotient = stage_ff[DIV_STAGES-1].quo;
   assign tag_out = stage_ff[DIV_STAGES-1].tag;

endmodule

@@ rtl/ensc_press.sv @@
module ensc_press (
   input  logic              clock,
   input  logic              adv,
   input  logic [31:0]       fine,
   input  logic [19:0]       adc_press,
   input  ensc_pkg::cal_type cal,
   output logic [31:0]       pressure
);
   import ensc_pkg::*;

   localparam int unsigned AP_DLY = FINE_LAT + 4;

   logic [19:0] ap_dly_ff [AP_DLY];
   logic [31:0] v1_in;
   logic [31:0] pv1_ff, q_ff, qq_ff, m5_ff, m2_ff, a_ff, b_ff, m5b_ff, m2b_ff;
   logic [31:0] v2_ff, v1c_ff, m_ff, n_ff, dsr_ff, pp_ff;
   logic [31:0] dvd, quo, p_in;
   div_tag_type tag_in, tag_out;
   logic [31:0] p_ff, s_ff, m8_ff, m9_ff, p2_ff, m8b_ff, pressure_ff;
   logic        z_ff, z2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ap_dly_ff[0] <= adc_press;
         for (int i = 1; i < AP_DLY; i++) begin
            ap_dly_ff[i] <= ap_dly_ff[i-1];
         end
      end
   end

   assign v1_in = asr(fine, 1) - 32'd64000;

   always_ff @(posedge clock) begin
      if (adv) begin
         pv1_ff <= v1_in;
         q_ff   <= asr(v1_in, 2);
         qq_ff  <= q_ff * q_ff;
         m5_ff  <= pv1_ff * cal.p5;
         m2_ff  <= cal.p2 * pv1_ff;
         a_ff   <= asr(qq_ff, 11) * cal.p6;
         b_ff   <= cal.p3 * asr(qq_ff, 13);
         m5b_ff <= m5_ff;
         m2b_ff <= m2_ff;
         v2_ff  <= asr(a_ff + (m5b_ff << 1), 2) + (cal.p4 << 16);
         v1c_ff <= asr(asr(b_ff, 3) + asr(m2b_ff, 1), 18);
         m_ff   <= (32'd32768 + v1c_ff) * cal.p1;
         n_ff   <= (32'd1048576 - 32'(ap_dly_ff[AP_DLY-1])) - asr(v2_ff, 12);
         dsr_ff <= asr(m_ff, 15);
         pp_ff  <= n_ff * 32'd3125;
      end
   end

   // large dividends are divided first and doubled after
   assign dvd = pp_ff[31] ? pp_ff : (pp_ff << 1);
   assign tag_in = '{dbl: pp_ff[31], zero: (dsr_ff == 32'd0)};

   ensc_div u_div (
      .clock    (clock),
      .adv      (adv),
      .dividend (dvd),
      .divisor  (dsr_ff),
      .tag_in   (tag_in),
      .quotient (quo),
      .tag_out  (tag_out)
   );

   assign p_in = tag_out.dbl ? (quo << 1) : quo;

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff   <= p_in;
         s_ff   <= (p_in >> 3) * (p_in >> 3);
         m8_ff  <= (p_in >> 2) * cal.p8;
         z_ff   <= tag_out.zero;
         m9_ff  <= cal.p9 * (s_ff >> 13);
         p2_ff  <= p_ff;
         m8b_ff <= m8_ff;
         z2_ff  <= z_ff;
         pressure_ff <= z2_ff ? 32'd0
                        : p2_ff + asr(asr(m9_ff, 12) + asr(m8b_ff, 13) + cal.p7, 4);
      end
   end

   assign pressure = pressure_ff;

endmodule

@@ rtl/ensc_hum.sv @@
module ensc_hum (
   input  logic              clock,
   input  logic              adv,
   input  logic [31:0]       fine,
   input  logic [15:0]       adc_hum,
   input  ensc_pkg::cal_type cal,
   output logic [16:0]       humidity
);
   import ensc_pkg::*;

   localparam int unsigned AH_DLY = FINE_LAT + 2;

   logic [15:0] ah_dly_ff [AH_DLY];
   logic [31:0] x_ff, hx5_ff, m6_ff, m3_ff, u_ff, w_ff, u2_ff, w2_ff, x2_ff;
   logic [31:0] qq_ff, x2b_ff, m_ff, x2c_ff, x3;
   logic [16:0] hum_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ah_dly_ff[0] <= adc_hum;
         for (int i = 1; i < AH_DLY; i++) begin
            ah_dly_ff[i] <= ah_dly_ff[i-1];
         end
      end
   end

   assign x3 = x2c_ff - asr(m_ff, 4);

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff   <= fine - 32'd76800;
         hx5_ff <= cal.h5 * x_ff;
         m6_ff  <= x_ff * cal.h6;
         m3_ff  <= x_ff * cal.h3;
         u_ff   <= asr((32'(ah_dly_ff[AH_DLY-1]) << 14) - (cal.h4 << 20) - hx5_ff
                       + 32'd16384, 15);
         w_ff   <= asr(m6_ff, 10) * (asr(m3_ff, 11) + 32'd32768);
         u2_ff  <= u_ff;
         w2_ff  <= (asr(w_ff, 10) + 32'd2097152) * cal.h2 + 32'd8192;
         x2_ff  <= u2_ff * asr(w2_ff, 14);
         qq_ff  <= asr(x2_ff, 15) * asr(x2_ff, 15);
         x2b_ff <= x2_ff;
         m_ff   <= asr(qq_ff, 7) * cal.h1;
         x2c_ff <= x2b_ff;
         // clamp to the valid humidity range before scaling down
         if (x3[31]) begin
            hum_ff <= '0;
         end else if (x3 > HUM_MAX) begin
            hum_ff <= 17'(HUM_MAX >> 12);
         end else begin
            hum_ff <= 17'(x3 >> 12);
         end
      end
   end

   assign humidity = hum_ff;

endmodule

@@ rtl/env_sensor_compensation.sv @@
// channel  | valid / flow       | payload
// ---------+--------------------+-----------------------------------------
// req      | req_valid/stall    | adc_temp[19:0] adc_press[19:0] adc_hum[15:0]
// rsp      | rsp_valid/stall    | temperature[31:0] pressure[31:0] humidity[16:0]
// csr      | csr_valid/ready    | index[2:0] data[47:0]
//
// one request per clock while req_stall is low; every request yields one response
// the response delay is set by the 32-stage restoring divider of the pressure path
// all stages advance together; a stalled response freezes the whole pipeline
// reset clears valid bits and calibration registers, data registers are not reset
// calibration writes are always taken; change them only while no request is in flight
module env_sensor_compensation (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [19:0]                        req_adc_temp,
   input  logic [19:0]                        req_adc_press,
   input  logic [15:0]                        req_adc_hum,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [31:0]                        rsp_temperature,
   output logic [31:0]                        rsp_pressure,
   output logic [16:0]                        rsp_humidity,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ensc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ensc_pkg::CSR_DATA_W-1:0]    csr_data
);
   import ensc_pkg::*;

   localparam int unsigned TEMP_DLY = PIPE_LAT - TEMP_LAT;
   localparam int unsigned HUM_DLY = PIPE_LAT - HUM_LAT;

   logic [47:0] cal_temp_ff, cal_press_a_ff, cal_press_b_ff, cal_press_c_ff;
   logic [31:0] cal_hum_a_ff;
   logic [39:0] cal_hum_b_ff;
   cal_type     cal;
   logic        adv;
   logic [PIPE_LAT-1:0] vld_ff;
   logic [31:0] fine, temp, pressure;
   logic [16:0] humidity;
   logic [31:0] temp_dly_ff [TEMP_DLY];
   logic [16:0] hum_dly_ff [HUM_DLY];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_temp_ff    <= '0;
         cal_press_a_ff <= '0;
         cal_press_b_ff <= '0;
         cal_press_c_ff <= '0;
         cal_hum_a_ff   <= '0;
         cal_hum_b_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CAL_TEMP:    cal_temp_ff    <= csr_data;
            CSR_CAL_PRESS_A: cal_press_a_ff <= csr_data;
            CSR_CAL_PRESS_B: cal_press_b_ff <= csr_data;
            CSR_CAL_PRESS_C: cal_press_c_ff <= csr_data;
            CSR_CAL_HUM_A:   cal_hum_a_ff   <= csr_data[31:0];
            CSR_CAL_HUM_B:   cal_hum_b_ff   <= csr_data[39:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cal.t1 = {16'd0, cal_temp_ff[47:32]};
      cal.t2 = sx16(cal_temp_ff[31:16]);
      cal.t3 = sx16(cal_temp_ff[15:0]);
      cal.p1 = {16'd0, cal_press_a_ff[47:32]};
      cal.p2 = sx16(cal_press_a_ff[31:16]);
      cal.p3 = sx16(cal_press_a_ff[15:0]);
      cal.p4 = sx16(cal_press_b_ff[47:32]);
      cal.p5 = sx16(cal_press_b_ff[31:16]);
      cal.p6 = sx16(cal_press_b_ff[15:0]);
      cal.p7 = sx16(cal_press_c_ff[47:32]);
      cal.p8 = sx16(cal_press_c_ff[31:16]);
      cal.p9 = sx16(cal_press_c_ff[15:0]);
      cal.h1 = {24'd0, cal_hum_a_ff[31:24]};
      cal.h2 = sx16(cal_hum_a_ff[23:8]);
      cal.h3 = sx8(cal_hum_a_ff[7:0]);
      cal.h4 = sx16(cal_hum_b_ff[39:24]);
      cal.h5 = sx16(cal_hum_b_ff[23:8]);
      cal.h6 = sx8(cal_hum_b_ff[7:0]);
   end

   // the whole pipeline holds while the response waits
   assign adv = !(vld_ff[PIPE_LAT-1] && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], req_valid};
      end
   end

   ensc_temp u_temp (
      .clock    (clock),
      .adv      (adv),
      .adc_temp (req_adc_temp),
      .cal      (cal),
      .fine     (fine),
      .temp     (temp)
   );

   ensc_press u_press (
      .clock     (clock),
      .adv       (adv),
      .fine      (fine),
      .adc_press (req_adc_press),
      .cal       (cal),
      .pressure  (pressure)
   );

   ensc_hum u_hum (
      .clock    (clock),
      .adv      (adv),
      .fine     (fine),
      .adc_hum  (req_adc_hum),
      .cal      (cal),
      .humidity (humidity)
   );

   // line up temperature and humidity with the slower pressure path
   always_ff @(posedge clock) begin
      if (adv) begin
         temp_dly_ff[0] <= temp;
         hum_dly_ff[0] <= humidity;
         for (int i = 1; i < TEMP_DLY; i++) begin
            temp_dly_ff[i] <= temp_dly_ff[i-1];
         end
         for (int i = 1; i < HUM_DLY; i++) begin
            hum_dly_ff[i] <= hum_dly_ff[i-1];
         end
      end
   end

   assign rsp_valid = vld_ff[PIPE_LAT-1];
   assign rsp_temperature = temp_dly_ff[TEMP_DLY-1];
   assign rsp_pressure = pressure;
   assign rsp_humidity = hum_dly_ff[HUM_DLY-1];

   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall does not follow the blocked response");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(vld_ff))
      else $error("pipeline moved during a stall");

   a_entry: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> vld_ff[0])
      else $error("accepted request did not enter the pipeline");

   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_humidity <= 17'd102400))
      else $error("humidity out of range");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import ensc_pkg::*;

   typedef struct packed {
      logic [31:0] temperature;
      logic [31:0] pressure;
      logic [16:0] humidity;
   } reading_type;

   // calibration copy and compensation formulas
   class compensation_scoreboard;
      logic [47:0] cal [6];
      reading_type pending [$];
      int errors;

      function new();
         foreach (cal[i]) cal[i] = '0;
         errors = 0;
      endfunction

      function void write_cal(logic [2:0] idx, logic [47:0] val);
         case (idx)
            CSR_CAL_TEMP, CSR_CAL_PRESS_A, CSR_CAL_PRESS_B, CSR_CAL_PRESS_C:
               cal[idx] = val;
            CSR_CAL_HUM_A: cal[idx] = {16'd0, val[31:0]};
            CSR_CAL_HUM_B: cal[idx] = {8'd0, val[39:0]};
            default: ;
         endcase
      endfunction

      function logic [31:0] sra(logic [31:0] x, int n);
         return 32'($signed(x) >>> n);
      endfunction

      function logic [31:0] s16(logic [15:0] v);
         return {{16{v[15]}}, v};
      endfunction

      function logic [31:0] s8(logic [7:0] v);
         return {{24{v[7]}}, v};
      endfunction

      function reading_type compensate(logic [19:0] at20, logic [19:0] ap20,
                                       logic [15:0] ah16);
         logic [31:0] at, ap, ah, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
         logic [31:0] h1, h2, h3, h4, h5, h6, v1, v2, d, fine, tmp, p, q, x, u, w;
         reading_type r;
         at = {12'd0, at20}; ap = {12'd0, ap20}; ah = {16'd0, ah16};
         t1 = {16'd0, cal[0][47:32]}; t2 = s16(cal[0][31:16]); t3 = s16(cal[0][15:0]);
         p1 = {16'd0, cal[1][47:32]}; p2 = s16(cal[1][31:16]); p3 = s16(cal[1][15:0]);
         p4 = s16(cal[2][47:32]); p5 = s16(cal[2][31:16]); p6 = s16(cal[2][15:0]);
         p7 = s16(cal[3][47:32]); p8 = s16(cal[3][31:16]); p9 = s16(cal[3][15:0]);
         h1 = {24'd0, cal[4][31:24]}; h2 = s16(cal[4][23:8]); h3 = s8(cal[4][7:0]);
         h4 = s16(cal[5][39:24]); h5 = s16(cal[5][23:8]); h6 = s8(cal[5][7:0]);

         v1 = sra(((at >> 3) - (t1 << 1)) * t2, 11);
         d = (at >> 4) - t1;
         v2 = sra(sra(d * d, 12) * t3, 14);
         fine = v1 + v2;
         tmp = sra(fine * 32'd5 + 32'd128, 8);

         v1 = sra(fine, 1) - 32'd64000;
         q = sra(v1, 2);
         v2 = sra(q * q, 11) * p6;
         v2 = v2 + ((v1 * p5) << 1);
         v2 = sra(v2, 2) + (p4 << 16);
         v1 = sra(sra(p3 * sra(q * q, 13), 3) + sra(p2 * v1, 1), 18);
         v1 = sra((32'd32768 + v1) * p1, 15);
         if (v1 == 0) begin
            p = 0;
         end else begin
            p = ((32'd1048576 - ap) - sra(v2, 12)) * 32'd3125;
            if (p < 32'h8000_0000) p = (p << 1) / v1;
            else p = (p / v1) * 32'd2;
            v1 = sra(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
            v2 = sra((p >> 2) * p8, 13);
            p = p + sra(v1 + v2 + p7, 4);
         end

         x = fine - 32'd76800;
         u = sra(((ah << 14) - (h4 << 20) - (h5 * x)) + 32'd16384, 15);
         w = sra(x * h6, 10) * (sra(x * h3, 11) + 32'd32768);
         w = (sra(w, 10) + 32'd2097152) * h2 + 32'd8192;
         w = sra(w, 14);
         x = u * w;
         q = sra(x, 15);
         x = x - sra(sra(q * q, 7) * h1, 4);
         if (x[31]) x = 0;
         else if (x > HUM_MAX) x = HUM_MAX;
         r.temperature = tmp;
         r.pressure = p;
         r.humidity = x[28:12];
         return r;
      endfunction

      function void note_request(logic [19:0] at, logic [19:0] ap, logic [15:0] ah);
         pending.push_back(compensate(at, ap, ah));
      endfunction

      task check_response(reading_type got);
         reading_type want;
         if (pending.size() == 0) begin
            report_mismatch("response with nothing outstanding", 0, 0);
            return;
         end
         want = pending.pop_front();
         if (got.temperature !== want.temperature)
            report_mismatch("temperature", got.temperature, want.temperature);
         if (got.pressure !== want.pressure)
            report_mismatch("pressure", got.pressure, want.pressure);
         if (got.humidity !== want.humidity)
            report_mismatch("humidity", got.humidity, want.humidity);
      endtask

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         if (errors <= 50)
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
      endtask
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall;
   logic [19:0] req_adc_temp = 0, req_adc_press = 0;
   logic [15:0] req_adc_hum = 0;
   logic rsp_valid, rsp_stall = 0;
   logic [31:0] rsp_temperature, rsp_pressure;
   logic [16:0] rsp_humidity;
   logic csr_valid = 0, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = 0;
   logic [CSR_DATA_W-1:0] csr_data = 0;

   compensation_scoreboard sb = new();
   int idle_pct = 0, stall_pct = 0;
   bit hold_off = 0;

   env_sensor_compensation u_top (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_request(req_adc_temp, req_adc_press, req_adc_hum);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response({rsp_temperature, rsp_pressure, rsp_humidity});
   end

   always @(negedge clock)
      rsp_stall <= hold_off || ($urandom_range(99) < stall_pct);

   task send_request(logic [19:0] at, logic [19:0] ap, logic [15:0] ah);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_adc_temp <= at;
      req_adc_press <= ap;
      req_adc_hum <= ah;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task write_csr(csr_reg_type idx, logic [47:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_cal(idx, val);
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   task drain;
      req_valid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (PIPE_LAT + 5) @(negedge clock);
   endtask

   function logic [47:0] rand48();
      return {$urandom(), $urandom()};
   endfunction

   // realistic calibration set with a random spread
   task load_typical;
      write_csr(CSR_CAL_TEMP, {16'(27504 + $urandom_range(2000) - 1000),
                               16'(26435 + $urandom_range(2000) - 1000), 16'(-1000)});
      write_csr(CSR_CAL_PRESS_A, {16'(36477 + $urandom_range(2000) - 1000),
                                  16'(-10685), 16'd3024});
      write_csr(CSR_CAL_PRESS_B, {16'd2855, 16'd140, 16'(-7)});
      write_csr(CSR_CAL_PRESS_C, {16'd15500, 16'(-14600), 16'd6000});
      write_csr(CSR_CAL_HUM_A, {8'd75, 16'd362, 8'd0});
      write_csr(CSR_CAL_HUM_B, {16'd310, 16'd50, 8'd30});
   endtask

   task random_batch(int n, bit typical);
      repeat (n) begin
         if (typical)
            send_request(20'($urandom_range(600000, 400000)),
                         20'($urandom_range(450000, 250000)), 16'($urandom()));
         else
            send_request(20'($urandom()), 20'($urandom()), 16'($urandom()));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: reset calibration (zero pressure divisor), field extremes
      send_request(0, 0, 0);
      send_request('1, '1, '1);
      send_request(20'h80000, 20'h7ffff, 16'h8000);
      drain();
      // out-of-range index must leave all registers alone
      write_csr(csr_reg_type'(3'd6), '1);
      write_csr(csr_reg_type'(3'd7), '1);
      load_typical();
      send_request(0, 0, 0);
      send_request('1, '1, '1);
      send_request(20'd519888, 20'd415148, 16'd0);
      send_request(20'd519888, 20'd415148, 16'hffff);
      send_request(20'd519888, 20'd0, 16'd30000);
      send_request(20'd519888, 20'hfffff, 16'd30000);
      drain();
      // all-ones calibration, then the 8000_8000_8080 pattern, humidity clamp extremes
      foreach (sb.cal[i]) write_csr(csr_reg_type'(i), '1);
      send_request(0, 0, 0);
      send_request('1, '1, '1);
      send_request(20'd500000, 20'd300000, 16'hffff);
      drain();
      foreach (sb.cal[i]) write_csr(csr_reg_type'(i), 48'h8000_8000_8080);
      send_request(0, 0, 0);
      send_request('1, '1, '1);
      send_request(20'd500000, 20'd300000, 16'h1234);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 51; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 51; end
            default: begin idle_pct = 18; stall_pct = 18; end
         endcase
         if (ph == 3) begin
            foreach (sb.cal[i]) write_csr(csr_reg_type'(i), rand48());
            random_batch(150, 0);
         end else begin
            load_typical();
            if (ph == 5) begin
               // long receiver hold-off while requests keep coming
               fork
                  begin
                     hold_off = 1;
                     repeat (200) @(negedge clock);
                     hold_off = 0;
                  end
                  random_batch(120, 1);
               join
            end
            random_batch(205, 1);
            random_batch(20, 0);
         end
         drain();
      end

      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end
endmodule
